@@ rtl/dcma_pkg.sv @@
package dcma_pkg;

	localparam int SAMPLE_W = 12;
	localparam int MEAN_W = 12;
	localparam int OP_W = 3;
	localparam int DEFAULT_WINDOW_LEN = 16;

	localparam logic [OP_W-1:0] OP_VSAMPLE = 3'd0;
	localparam logic [OP_W-1:0] OP_ISAMPLE = 3'd1;
	localparam logic [OP_W-1:0] OP_VPREFILL = 3'd2;
	localparam logic [OP_W-1:0] OP_ENABLE = 3'd3;
	localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [SAMPLE_W-1:0] sample;
	} dcma_in_t;

	typedef struct packed {
		logic [MEAN_W-1:0] voltage_mean;
		logic [MEAN_W-1:0] current_mean;
		logic load_enabled;
	} dcma_out_t;

	typedef struct packed {
		logic shift;
		logic [SAMPLE_W-1:0] data;
	} dcma_lane_ctl_t;

endpackage

@@ rtl/dcma_cell.sv @@
module dcma_cell
	import dcma_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic shift,
	input logic [SAMPLE_W-1:0] d,
	output logic [SAMPLE_W-1:0] q
);

	logic [SAMPLE_W-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

@@ rtl/dcma_lane.sv @@
module dcma_lane
	import dcma_pkg::*;
#(
	parameter int WINDOW_LEN = DEFAULT_WINDOW_LEN
) (
	input logic clk,
	input logic arst_n,
	input dcma_lane_ctl_t ctl,
	output logic [SAMPLE_W+$clog2(WINDOW_LEN)-1:0] sum
);

	localparam int SW = SAMPLE_W + $clog2(WINDOW_LEN);

	logic [SAMPLE_W-1:0] tap [WINDOW_LEN];
	logic [SW-1:0] sum_q;

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		logic [SAMPLE_W-1:0] cell_d;
		if (i == 0) begin : g_head
			assign cell_d = ctl.data;
		end else begin : g_body
			assign cell_d = tap[i-1];
		end
		dcma_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.shift(ctl.shift),
			.d(cell_d),
			.q(tap[i])
		);
	end

	// The oldest sample leaves the far end of the chain as the new one enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.shift) begin
			sum_q <= sum_q - SW'(tap[WINDOW_LEN-1]) + SW'(ctl.data);
		end
	end

	assign sum = sum_q;

endmodule

@@ rtl/dcma_div.sv @@
module dcma_div
	import dcma_pkg::*;
#(
	parameter int WINDOW_LEN = DEFAULT_WINDOW_LEN
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [SAMPLE_W+$clog2(WINDOW_LEN)-1:0] dividend,
	output logic done,
	output logic [MEAN_W-1:0] quotient
);

	localparam int LW = $clog2(WINDOW_LEN);
	localparam int SW = SAMPLE_W + LW;
	localparam int SH = SW + LW;
	localparam int MW = SW + 2;
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);

	logic [MW-1:0] recip;
	logic [SW+MW-1:0] product;
	logic [MEAN_W-1:0] quo_q;
	logic done_q;

	// The reciprocal is rounded up with SH fraction bits, which makes the
	// truncated quotient exact for every dividend of SW bits.
	assign recip = MW'(RECIP);
	assign product = {{MW{1'b0}}, dividend} * {{SW{1'b0}}, recip};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= product[SH +: MEAN_W];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/dual_channel_moving_average_unit.sv @@
// Dual boxcar averager for a voltage and a current reading.
// Input channel: item, item_valid, item_stall. Each beat carries an action
// code and a 12-bit sample. Output channel: result, result_valid,
// result_stall. Every input beat yields exactly one result beat holding both
// means and the load-enable flag as they stand after the action.
// Each channel keeps its window in a chain of sample cells that shift by one
// per cycle while enabled, plus a running sum. A sample action shifts once,
// a current sample only while the load is enabled; a prefill, enable or
// disable shifts the fill value in WINDOW_LEN times. The means then come
// from a multiplication by the reciprocal of the window length, registered
// once. After acceptance the unit runs the shifts, starts both dividers and
// loads the result register when both report done. The next beat is
// accepted once the unit is back in idle.
// One item is worked on at a time; item_stall is high from acceptance until
// the result register is loaded. Under result_stall the result holds and a
// finished second item waits until the register frees.
// Reset clears both windows, both sums and the flag, not the result register.
module dual_channel_moving_average_unit
	import dcma_pkg::*;
#(
	parameter int WINDOW_LEN = DEFAULT_WINDOW_LEN
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input dcma_in_t item,
	output logic result_valid,
	input logic result_stall,
	output dcma_out_t result
);

	localparam int SW = SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int CW = $clog2(WINDOW_LEN);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_HOLD = 3'd4;

	logic [2:0] state_q;
	logic [CW-1:0] cnt_q;
	logic on_q;
	logic v_act_q, v_fill_q, c_act_q, c_fill_q;
	logic [SAMPLE_W-1:0] v_data_q, c_data_q;
	logic v_act_d, v_fill_d, c_act_d, c_fill_d, on_d;
	logic [SAMPLE_W-1:0] c_data_d;
	logic accept;
	logic run;
	logic out_free;
	logic div_start;
	logic div_done;
	logic load_result;
	logic v_done, c_done;
	logic [SW-1:0] v_sum, c_sum;
	logic [MEAN_W-1:0] v_quo, c_quo;
	dcma_lane_ctl_t v_ctl, c_ctl;
	dcma_out_t result_q;
	logic result_valid_q;

	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid && !item_stall;
	assign run = (state_q == ST_RUN);
	assign out_free = !result_valid_q || !result_stall;
	assign div_start = (state_q == ST_START);
	assign div_done = v_done && c_done;
	assign load_result = ((state_q == ST_DIV && div_done) || state_q == ST_HOLD) && out_free;

	always_comb begin
		v_act_d = 1'b0;
		v_fill_d = 1'b0;
		c_act_d = 1'b0;
		c_fill_d = 1'b0;
		c_data_d = item.sample;
		on_d = on_q;
		case (item.op)
			OP_VSAMPLE: begin
				v_act_d = 1'b1;
			end
			OP_ISAMPLE: begin
				c_act_d = on_q;
			end
			OP_VPREFILL: begin
				v_act_d = 1'b1;
				v_fill_d = 1'b1;
			end
			OP_ENABLE: begin
				c_act_d = 1'b1;
				c_fill_d = 1'b1;
				on_d = 1'b1;
			end
			OP_DISABLE: begin
				c_act_d = 1'b1;
				c_fill_d = 1'b1;
				c_data_d = '0;
				on_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			on_q <= 1'b0;
			v_act_q <= 1'b0;
			v_fill_q <= 1'b0;
			c_act_q <= 1'b0;
			c_fill_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						v_act_q <= v_act_d;
						v_fill_q <= v_fill_d;
						c_act_q <= c_act_d;
						c_fill_q <= c_fill_d;
						on_q <= on_d;
						cnt_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!(v_fill_q || c_fill_q) || cnt_q == CW'(WINDOW_LEN - 1)) begin
						cnt_q <= '0;
						state_q <= ST_START;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_data_q <= item.sample;
			c_data_q <= c_data_d;
		end
		if (load_result) begin
			result_q.voltage_mean <= v_quo;
			result_q.current_mean <= c_quo;
			result_q.load_enabled <= on_q;
		end
	end

	always_comb begin
		v_ctl.shift = run && v_act_q && (v_fill_q || cnt_q == '0);
		v_ctl.data = v_data_q;
		c_ctl.shift = run && c_act_q && (c_fill_q || cnt_q == '0);
		c_ctl.data = c_data_q;
	end

	dcma_lane #(.WINDOW_LEN(WINDOW_LEN)) u_vlane (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(v_ctl),
		.sum(v_sum)
	);

	dcma_lane #(.WINDOW_LEN(WINDOW_LEN)) u_clane (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(c_ctl),
		.sum(c_sum)
	);

	dcma_div #(.WINDOW_LEN(WINDOW_LEN)) u_vdiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(v_sum),
		.done(v_done),
		.quotient(v_quo)
	);

	dcma_div #(.WINDOW_LEN(WINDOW_LEN)) u_cdiv (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(c_sum),
		.done(c_done),
		.quotient(c_quo)
	);

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

@@ bench/dual_channel_moving_average_unit_test.sv @@
module dual_channel_moving_average_unit_test;
	import dcma_pkg::*;

	localparam int WIN = DEFAULT_WINDOW_LEN;
	localparam int RANDOM_ITEMS = 1900;
	localparam int SCRIPT_LEN = 24;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_WAIT = 13;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam dcma_out_t NO_MEANS = '0;

	typedef enum int {CH_VOLT, CH_CURR} channel_t;

	typedef struct packed {
		logic typed;
		dcma_in_t beat;
		dcma_out_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	dcma_in_t item;
	logic result_valid;
	logic result_stall;
	dcma_out_t result;

	logic [SAMPLE_W-1:0] taps [2][WIN];
	int unsigned total [2];
	int unsigned slot [2];
	bit load_on;

	dcma_out_t pending_means [$];
	script_row_t script [SCRIPT_LEN];
	bit send_quiet;
	int errors;
	int beats_sent;
	int results_seen;
	int cycles;

	dual_channel_moving_average_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #10 clk = ~clk;

	function automatic void shift_in(input channel_t ch, input logic [SAMPLE_W-1:0] v);
		total[ch] = total[ch] - taps[ch][slot[ch]] + v;
		taps[ch][slot[ch]] = v;
		slot[ch] = (slot[ch] + 1) % WIN;
	endfunction

	function automatic void flood(input channel_t ch, input logic [SAMPLE_W-1:0] v);
		for (int k = 0; k < WIN; k++)
			taps[ch][k] = v;
		total[ch] = v * WIN;
	endfunction

	function automatic dcma_out_t advance_filters(input dcma_in_t beat);
		dcma_out_t m;
		case (beat.op)
			OP_VSAMPLE: shift_in(CH_VOLT, beat.sample);
			OP_ISAMPLE: if (load_on) shift_in(CH_CURR, beat.sample);
			OP_VPREFILL: flood(CH_VOLT, beat.sample);
			OP_ENABLE: begin
				flood(CH_CURR, beat.sample);
				load_on = 1'b1;
			end
			OP_DISABLE: begin
				flood(CH_CURR, '0);
				load_on = 1'b0;
			end
			default: ;
		endcase
		m.voltage_mean = MEAN_W'(total[CH_VOLT] / WIN);
		m.current_mean = MEAN_W'(total[CH_CURR] / WIN);
		m.load_enabled = load_on;
		return m;
	endfunction

	task automatic offer_item(input dcma_in_t beat, input bit typed, input dcma_out_t typed_want);
		int gap;
		dcma_out_t want;
		if ($urandom_range(0, 39) == 0)
			send_quiet = !send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= beat;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		want = advance_filters(beat);
		pending_means.push_back(typed ? typed_want : want);
		beats_sent++;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding", $time, pending_means.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin : check_result
		dcma_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, result);
				errors++;
			end else begin
				want = pending_means.pop_front();
				if (result.voltage_mean !== want.voltage_mean) begin
					$display("%0t: voltage_mean expected %0d, actual %0d",
						$time, want.voltage_mean, result.voltage_mean);
					errors++;
				end
				if (result.current_mean !== want.current_mean) begin
					$display("%0t: current_mean expected %0d, actual %0d",
						$time, want.current_mean, result.current_mean);
					errors++;
				end
				if (result.load_enabled !== want.load_enabled) begin
					$display("%0t: load_enabled expected %0d, actual %0d",
						$time, want.load_enabled, result.load_enabled);
					errors++;
				end
			end
		end
	end

	initial begin : receiver
		int hold;
		bit quiet;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				quiet = !quiet;
			hold = quiet ? 0 : $urandom_range(0, MAX_WAIT);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	initial begin : stimulus
		dcma_in_t beat;
		int roll;
		int counted;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		result_stall <= 1'b0;
		flood(CH_VOLT, '0);
		flood(CH_CURR, '0);
		script = '{
			{1'b1, OP_SPARE_LO, 12'hFFF, 12'h000, 12'h000, 1'b0},
			{1'b1, OP_ISAMPLE, 12'hFFF, 12'h000, 12'h000, 1'b0},
			{1'b1, OP_DISABLE, 12'hFFF, 12'h000, 12'h000, 1'b0},
			{1'b1, OP_VPREFILL, 12'hFFF, 12'hFFF, 12'h000, 1'b0},
			{1'b0, OP_VSAMPLE, 12'h000, NO_MEANS},
			{1'b0, OP_VSAMPLE, 12'hFFF, NO_MEANS},
			{1'b0, OP_ENABLE, 12'hFFF, NO_MEANS},
			{1'b0, OP_ISAMPLE, 12'h000, NO_MEANS},
			{1'b0, OP_ISAMPLE, 12'h800, NO_MEANS},
			{1'b0, OP_ENABLE, 12'hABC, NO_MEANS},
			{1'b0, OP_ISAMPLE, 12'h555, NO_MEANS},
			{1'b0, OP_SPARE_MID, 12'h123, NO_MEANS},
			{1'b0, OP_VPREFILL, 12'h000, NO_MEANS},
			{1'b1, OP_DISABLE, 12'h000, 12'h000, 12'h000, 1'b0},
			{1'b1, OP_DISABLE, 12'hFFF, 12'h000, 12'h000, 1'b0},
			{1'b1, OP_ISAMPLE, 12'h7FF, 12'h000, 12'h000, 1'b0},
			{1'b1, OP_ENABLE, 12'h000, 12'h000, 12'h000, 1'b1},
			{1'b0, OP_ISAMPLE, 12'hFFF, NO_MEANS},
			{1'b0, OP_VSAMPLE, 12'hAAA, NO_MEANS},
			{1'b0, OP_VPREFILL, 12'h555, NO_MEANS},
			{1'b0, OP_VSAMPLE, 12'h001, NO_MEANS},
			{1'b0, OP_SPARE_HI, 12'hFFF, NO_MEANS},
			{1'b0, OP_ENABLE, 12'hFFF, NO_MEANS},
			{1'b0, OP_DISABLE, 12'h000, NO_MEANS}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++)
			offer_item(script[i].beat, script[i].typed, script[i].want);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 36)
				beat.op = OP_VSAMPLE;
			else if (roll < 72)
				beat.op = OP_ISAMPLE;
			else if (roll < 80)
				beat.op = OP_VPREFILL;
			else if (roll < 88)
				beat.op = OP_ENABLE;
			else if (roll < 94)
				beat.op = OP_DISABLE;
			else
				beat.op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
			roll = $urandom_range(0, 7);
			if (roll == 0)
				beat.sample = '0;
			else if (roll == 1)
				beat.sample = '1;
			else
				beat.sample = SAMPLE_W'($urandom);
			counted++;
			offer_item(beat, 1'b0, NO_MEANS);
		end
		item_valid <= 1'b0;

		while (pending_means.size() != 0)
			@(posedge clk);
		repeat (WIN + 30) @(posedge clk);

		$display("Sent %0d beats (%0d scripted, the rest random over all actions and spare codes);",
			beats_sent, SCRIPT_LEN);
		$display("checked %0d result beats against the predicted means, %0d mismatches.",
			results_seen, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
